FILE: hw/rtl/ilpe_pkg.sv
package ilpe_pkg;

   localparam int CHANNELS   = 5;
   localparam int LEVEL_BITS = 17;
   localparam int DEV_LIMIT  = 300;

   // register indexes
   localparam logic [2:0] REG_LEFT_TRANSIT  = 3'd0;
   localparam logic [2:0] REG_RIGHT_TRANSIT = 3'd1;
   localparam logic [2:0] REG_RAW_LOW       = 3'd2;
   localparam logic [2:0] REG_EQUAL_SPREAD  = 3'd3;
   localparam logic [2:0] REG_MAX_CENTER    = 3'd4;
   localparam logic [2:0] REG_WEAK_SIGNAL   = 3'd5;
   localparam logic [2:0] REG_LOST_DEV      = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM_START,
      ST_NORM_WAIT,
      ST_DECIDE,
      ST_OUTPUT
   } state_type;

   // divider handshake between sequencer and shared divider
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

FILE: hw/rtl/inductor_line_position_estimator_top.sv
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tdata: left,center,right,aux_a,aux_b raw; tuser: idle
// rsp     | out | rsp_tvalid/tready   | tdata: position,deviation,5 levels
// csr     | in  | csr_wen             | csr_index, csr_wdata
//
// Each item is worked channel by channel through the shared bit-serial divider (start
// state, then a wait for done per channel; a channel at its floor or saturation skips
// the divider).
// req_tready is low from acceptance until the result is taken on rsp.
// Reset (synchronous) restores minima 47, maxima 2000, registers to defaults.
// A stalled result holds rsp_tdata; no new item is taken meanwhile.
module inductor_line_position_estimator_top #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // left_raw, center_raw, right_raw, aux_a_raw, aux_b_raw from lowest bit
   input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // roundabout_idle
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // line_position, deviation, left, center, right, aux_a, aux_b levels
   output logic [103:0]              rsp_tdata,
   input  logic                      csr_wen,
   input  logic [2:0]                csr_index,
   input  logic [11:0]               csr_wdata
);

   localparam int NCH      = ilpe_pkg::CHANNELS;
   localparam int LB       = ilpe_pkg::LEVEL_BITS;
   localparam int NUM_BITS = SAMPLE_BITS + FRAC_BITS + 7;
   localparam int CH_BITS  = 3;
   localparam logic [LB-1:0] LEVEL_MAX   = {LB{1'b1}};
   localparam logic [LB-1:0] LEVEL_FLOOR = LB'(((1 << FRAC_BITS) + 5) / 10);

   // configuration registers
   logic [7:0]  left_transit_ff, right_transit_ff, equal_spread_ff;
   logic [7:0]  max_center_ff, weak_signal_ff;
   logic [11:0] raw_low_ff;
   logic [8:0]  lost_dev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_transit_ff  <= 8'd30;
         right_transit_ff <= 8'd30;
         raw_low_ff       <= 12'd500;
         equal_spread_ff  <= 8'd5;
         max_center_ff    <= 8'd90;
         weak_signal_ff   <= 8'd5;
         lost_dev_ff      <= 9'd60;
      end else if (csr_wen) begin
         case (csr_index)
            ilpe_pkg::REG_LEFT_TRANSIT:  left_transit_ff  <= csr_wdata[7:0];
            ilpe_pkg::REG_RIGHT_TRANSIT: right_transit_ff <= csr_wdata[7:0];
            ilpe_pkg::REG_RAW_LOW:       raw_low_ff       <= csr_wdata;
            ilpe_pkg::REG_EQUAL_SPREAD:  equal_spread_ff  <= csr_wdata[7:0];
            ilpe_pkg::REG_MAX_CENTER:    max_center_ff    <= csr_wdata[7:0];
            ilpe_pkg::REG_WEAK_SIGNAL:   weak_signal_ff   <= csr_wdata[7:0];
            ilpe_pkg::REG_LOST_DEV:      lost_dev_ff      <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   ilpe_pkg::state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0] raw_ff [NCH];
   logic [SAMPLE_BITS-1:0] min_ff [NCH];
   logic [SAMPLE_BITS-1:0] max_ff [NCH];
   logic [LB-1:0]          lvl_ff [NCH];
   logic [LB-1:0]          lvl_in;
   logic [LB-1:0]          prev_center_ff;
   logic [1:0]             held_ff, settled_ff, pos_ff;
   logic [1:0]             held_in, settled_in, pos_in;
   logic [CH_BITS-1:0]     ch_ff;
   logic [1:0]             out_pos_ff;
   logic [9:0]             out_dev_ff;
   logic [9:0]             dev_in;
   logic                   accept, rsp_take;
   ilpe_pkg::div_ctrl_type div;
   logic [NUM_BITS-1:0]    div_num, div_q;
   logic [SAMPLE_BITS-1:0] div_den;
   logic                   ch_floor, ch_sat;

   assign accept   = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // raw fields and calibration decisions
   logic [SAMPLE_BITS-1:0] in_raw [NCH];
   logic [SAMPLE_BITS-1:0] new_min [NCH];
   logic [SAMPLE_BITS-1:0] new_max [NCH];
   logic cal_front, cal_aux, grow;

   function automatic logic near_eq(input logic [SAMPLE_BITS-1:0] a,
                                    input logic [SAMPLE_BITS-1:0] b,
                                    input logic [7:0] spread);
      logic [SAMPLE_BITS-1:0] d;
      d = (a > b) ? a - b : b - a;
      return {8'd0, d} < {{SAMPLE_BITS{1'b0}}, spread};
   endfunction

   logic [SAMPLE_BITS+11:0] raw_low_ext;
   assign raw_low_ext = {{SAMPLE_BITS{1'b0}}, raw_low_ff};

   function automatic logic below(input logic [SAMPLE_BITS-1:0] r,
                                  input logic [SAMPLE_BITS+11:0] lim);
      return {12'd0, r} < lim;
   endfunction

   always_comb begin
      for (int i = 0; i < NCH; i++)
         in_raw[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      cal_front = below(in_raw[0], raw_low_ext) && below(in_raw[1], raw_low_ext) &&
                  below(in_raw[2], raw_low_ext) &&
                  near_eq(in_raw[0], in_raw[1], equal_spread_ff) &&
                  near_eq(in_raw[0], in_raw[2], equal_spread_ff) &&
                  near_eq(in_raw[1], in_raw[2], equal_spread_ff);
      cal_aux   = below(in_raw[3], raw_low_ext) && below(in_raw[4], raw_low_ext) &&
                  near_eq(in_raw[1], in_raw[3], equal_spread_ff) &&
                  near_eq(in_raw[1], in_raw[4], equal_spread_ff);
      grow      = req_tuser &&
                  ({7'd0, prev_center_ff} < ({16'd0, max_center_ff} << FRAC_BITS));
      for (int i = 0; i < NCH; i++) begin
         new_min[i] = min_ff[i];
         if (cal_front && (i < 3 || cal_aux))
            new_min[i] = in_raw[i];
         new_max[i] = max_ff[i];
         if (grow && i != 1 && in_raw[i] > max_ff[i])
            new_max[i] = in_raw[i];
      end
   end

   // divider operands for the channel in work
   logic [SAMPLE_BITS-1:0] cur_raw, cur_min, cur_max;
   logic [SAMPLE_BITS-1:0] diff;
   assign cur_raw  = raw_ff[ch_ff];
   assign cur_min  = min_ff[ch_ff];
   assign cur_max  = max_ff[ch_ff];
   assign ch_floor = cur_raw <= cur_min;
   assign ch_sat   = cur_max <= cur_min;
   assign diff     = cur_raw - cur_min;
   // (raw-min)*100 = (d<<6)+(d<<5)+(d<<2), then shifted by FRAC_BITS
   assign div_num  = ((NUM_BITS'(diff) << 6) + (NUM_BITS'(diff) << 5)
                      + (NUM_BITS'(diff) << 2)) << FRAC_BITS;
   assign div_den  = cur_max - cur_min;
   assign div.start = (state_ff == ilpe_pkg::ST_NORM_START) && !ch_floor && !ch_sat;

   ilpe_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(SAMPLE_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div.start),
      .numer (div_num),
      .denom (div_den),
      .busy  (div.busy),
      .done  (div.done),
      .quot  (div_q)
   );

   always_comb begin
      if (div_q == '0)
         lvl_in = LEVEL_FLOOR;
      else if (div_q > NUM_BITS'(LEVEL_MAX))
         lvl_in = LEVEL_MAX;
      else
         lvl_in = div_q[LB-1:0];
   end

   // strongest channel, position and deviation
   logic [1:0]    strongest, strong_raw;
   logic [1:0]    pos_cand;
   logic [LB+7:0] lt, rt, weak_thr;
   logic [LB-1:0] sl;
   logic [LB:0]   dif;
   logic [LB-FRAC_BITS:0] mag;
   logic [8:0]    lmag;

   always_comb begin
      lt       = {{LB{1'b0}}, left_transit_ff} << FRAC_BITS;
      rt       = {{LB{1'b0}}, right_transit_ff} << FRAC_BITS;
      weak_thr = {{LB{1'b0}}, weak_signal_ff} << FRAC_BITS;
      strong_raw = 2'd0;
      sl = lvl_ff[0];
      if (sl < lvl_ff[1]) begin
         strong_raw = 2'd1;
         sl = lvl_ff[1];
      end
      if (sl < lvl_ff[2]) begin
         strong_raw = 2'd2;
         sl = lvl_ff[2];
      end
      held_in = held_ff;
      if ({8'd0, sl} < weak_thr)
         strongest = (held_ff > 2'd2) ? 2'd2 : held_ff;
      else begin
         strongest = strong_raw;
         held_in   = strong_raw;
      end
      settled_in = settled_ff;
      if (((strongest > settled_ff) ? strongest - settled_ff
                                    : settled_ff - strongest) < 2'd2)
         settled_in = strongest;
      else
         strongest = settled_ff;

      if (strongest == 2'd0 && {8'd0, lvl_ff[1]} <= lt &&
          {12'd0, raw_ff[0]} > raw_low_ext)
         pos_cand = 2'd0;
      else if ((strongest == 2'd0 && {8'd0, lvl_ff[1]} > lt) ||
               (strongest == 2'd1 && lvl_ff[0] > lvl_ff[2]))
         pos_cand = 2'd1;
      else if ((strongest == 2'd1 && lvl_ff[2] > lvl_ff[0]) ||
               (strongest == 2'd2 && {8'd0, lvl_ff[1]} > rt))
         pos_cand = 2'd2;
      else if (strongest == 2'd2 && {8'd0, lvl_ff[1]} <= rt &&
               {12'd0, raw_ff[2]} > raw_low_ext)
         pos_cand = 2'd3;
      else
         pos_cand = pos_ff;
      pos_in = pos_cand;
      if (((pos_cand > pos_ff) ? pos_cand - pos_ff : pos_ff - pos_cand) > 2'd1)
         pos_in = pos_ff;

      lmag = (lost_dev_ff > 9'(ilpe_pkg::DEV_LIMIT)) ? 9'(ilpe_pkg::DEV_LIMIT) : lost_dev_ff;
      dif  = '0;
      mag  = '0;
      if (pos_in == 2'd0)
         dev_in = -{1'b0, lmag};
      else if (pos_in == 2'd3)
         dev_in = {1'b0, lmag};
      else if (lvl_ff[2] >= lvl_ff[0]) begin
         dif = {1'b0, lvl_ff[2]} - {1'b0, lvl_ff[0]};
         mag = dif[LB:FRAC_BITS];
         dev_in = (mag > (LB-FRAC_BITS+1)'(ilpe_pkg::DEV_LIMIT)) ?
                  10'(ilpe_pkg::DEV_LIMIT) : 10'(mag);
      end else begin
         dif = {1'b0, lvl_ff[0]} - {1'b0, lvl_ff[2]};
         mag = dif[LB:FRAC_BITS];
         dev_in = (mag > (LB-FRAC_BITS+1)'(ilpe_pkg::DEV_LIMIT)) ?
                  -10'(ilpe_pkg::DEV_LIMIT) : -10'(mag);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ilpe_pkg::ST_IDLE:       if (accept) state_in = ilpe_pkg::ST_NORM_START;
         ilpe_pkg::ST_NORM_START: begin
            if (ch_floor || ch_sat)
               state_in = (ch_ff == CH_BITS'(NCH-1)) ? ilpe_pkg::ST_DECIDE
                                                     : ilpe_pkg::ST_NORM_START;
            else
               state_in = ilpe_pkg::ST_NORM_WAIT;
         end
         ilpe_pkg::ST_NORM_WAIT: begin
            if (div.done)
               state_in = (ch_ff == CH_BITS'(NCH-1)) ? ilpe_pkg::ST_DECIDE
                                                     : ilpe_pkg::ST_NORM_START;
         end
         ilpe_pkg::ST_DECIDE:     state_in = ilpe_pkg::ST_OUTPUT;
         ilpe_pkg::ST_OUTPUT:     if (rsp_take) state_in = ilpe_pkg::ST_IDLE;
         default:                 state_in = ilpe_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == ilpe_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == ilpe_pkg::ST_OUTPUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ilpe_pkg::ST_IDLE;
         ch_ff          <= '0;
         prev_center_ff <= '0;
         held_ff        <= 2'd1;
         settled_ff     <= 2'd1;
         pos_ff         <= 2'd1;
         for (int i = 0; i < NCH; i++) begin
            min_ff[i] <= SAMPLE_BITS'(47);
            max_ff[i] <= SAMPLE_BITS'(2000);
         end
      end else begin
         state_ff <= state_in;
         if (accept) begin
            ch_ff <= '0;
            for (int i = 0; i < NCH; i++) begin
               min_ff[i] <= new_min[i];
               max_ff[i] <= new_max[i];
            end
         end
         // advance channel after each level is known
         if ((state_ff == ilpe_pkg::ST_NORM_START && (ch_floor || ch_sat)) ||
             (state_ff == ilpe_pkg::ST_NORM_WAIT && div.done))
            ch_ff <= ch_ff + 1'b1;
         if (state_ff == ilpe_pkg::ST_DECIDE) begin
            held_ff        <= held_in;
            settled_ff     <= settled_in;
            pos_ff         <= pos_in;
            prev_center_ff <= lvl_ff[1];
         end
      end
      if (accept)
         for (int i = 0; i < NCH; i++)
            raw_ff[i] <= in_raw[i];
      if (state_ff == ilpe_pkg::ST_NORM_START && ch_floor)
         lvl_ff[ch_ff] <= LEVEL_FLOOR;
      else if (state_ff == ilpe_pkg::ST_NORM_START && ch_sat)
         lvl_ff[ch_ff] <= LEVEL_MAX;
      else if (state_ff == ilpe_pkg::ST_NORM_WAIT && div.done)
         lvl_ff[ch_ff] <= lvl_in;
      if (state_ff == ilpe_pkg::ST_DECIDE) begin
         out_pos_ff <= pos_in;
         out_dev_ff <= dev_in;
      end
   end

   assign rsp_tdata = {7'd0, lvl_ff[4], lvl_ff[3], lvl_ff[2], lvl_ff[1], lvl_ff[0],
                       out_dev_ff, out_pos_ff};

   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("accepting while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ilpe_pkg::ST_DECIDE) |=> rsp_tvalid)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      div.busy |-> state_ff == ilpe_pkg::ST_NORM_WAIT)
      else $error("divider busy outside wait");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

FILE: hw/rtl/ilpe_divider.sv
// Restoring divider, one quotient bit per cycle.
module ilpe_divider #(
   parameter int NUM_BITS = 28,
   parameter int DEN_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                busy,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;

   // shift in one numerator bit, subtract when it fits
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_BITS-1:0], quot_ff[NUM_BITS-1]};
      if (start && !busy_ff) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider count underflow");

endmodule

FILE: verif/inductor_line_position_estimator_top_tb.sv
// Line position estimator test: directed corners, then random frames with bursty
// input and a stalling receiver; every result is checked against a local predictor.
class estimate_board;
   bit [11:0]  reg_ltrans, reg_rtrans, reg_rawlow, reg_spread, reg_maxc, reg_weak, reg_lost;
   bit [11:0]  ch_min[5];
   bit [11:0]  ch_max[5];
   bit [16:0]  prev_center;
   bit [1:0]   held_str, settled_str, cur_pos;
   bit [103:0] pending[$];
   int         errors;

   function new();
      reg_ltrans = 30; reg_rtrans = 30; reg_rawlow = 500; reg_spread = 5;
      reg_maxc = 90; reg_weak = 5; reg_lost = 60;
      foreach (ch_min[i]) begin
         ch_min[i] = 47;
         ch_max[i] = 2000;
      end
      prev_center = 0; held_str = 1; settled_str = 1; cur_pos = 1;
      errors = 0;
   endfunction

   function void write_reg(bit [2:0] idx, bit [11:0] val);
      case (idx)
         ilpe_pkg::REG_LEFT_TRANSIT:  reg_ltrans = val[7:0];
         ilpe_pkg::REG_RIGHT_TRANSIT: reg_rtrans = val[7:0];
         ilpe_pkg::REG_RAW_LOW:       reg_rawlow = val;
         ilpe_pkg::REG_EQUAL_SPREAD:  reg_spread = val[7:0];
         ilpe_pkg::REG_MAX_CENTER:    reg_maxc = val[7:0];
         ilpe_pkg::REG_WEAK_SIGNAL:   reg_weak = val[7:0];
         ilpe_pkg::REG_LOST_DEV:      reg_lost = val[8:0];
         default: ;
      endcase
   endfunction

   function bit close(int a, int b);
      int d;
      d = a > b ? a - b : b - a;
      return d < reg_spread;
   endfunction

   function int scale(int raw, int lo, int hi);
      longint q;
      if (raw <= lo) return 26;
      if (hi <= lo) return 131071;
      q = (longint'(raw - lo) * 100 * 256) / (hi - lo);
      if (q == 0) return 26;
      return q > 131071 ? 131071 : int'(q);
   endfunction

   // compute the expected result of one accepted frame
   function void note_frame(bit [59:0] data, bit idle);
      int raw[5];
      int lvl[5];
      int str, pos, prv, gap, mag, dev, lt, rt;
      bit [9:0] dv;
      for (int i = 0; i < 5; i++) raw[i] = data[i*12 +: 12];
      if (raw[0] < reg_rawlow && raw[1] < reg_rawlow && raw[2] < reg_rawlow &&
          close(raw[0], raw[1]) && close(raw[0], raw[2]) && close(raw[1], raw[2])) begin
         for (int i = 0; i < 3; i++) ch_min[i] = 12'(raw[i]);
         if (raw[3] < reg_rawlow && raw[4] < reg_rawlow &&
             close(raw[1], raw[3]) && close(raw[1], raw[4])) begin
            ch_min[3] = 12'(raw[3]);
            ch_min[4] = 12'(raw[4]);
         end
      end
      if (idle && prev_center < (int'(reg_maxc) << 8))
         for (int i = 0; i < 5; i++)
            if (i != 1 && raw[i] > ch_max[i]) ch_max[i] = 12'(raw[i]);
      for (int i = 0; i < 5; i++) lvl[i] = scale(raw[i], ch_min[i], ch_max[i]);
      // strongest front channel with weak hold and jump rejection
      str = 0;
      for (int i = 1; i < 3; i++) if (lvl[str] < lvl[i]) str = i;
      if (lvl[str] < (int'(reg_weak) << 8)) str = held_str > 2 ? 2 : int'(held_str);
      else held_str = 2'(str);
      gap = str > settled_str ? str - settled_str : settled_str - str;
      if (gap < 2) settled_str = 2'(str);
      else str = int'(settled_str);
      lt = int'(reg_ltrans) << 8;
      rt = int'(reg_rtrans) << 8;
      prv = int'(cur_pos);
      if (str == 0 && lvl[1] <= lt && raw[0] > reg_rawlow) pos = 0;
      else if ((str == 0 && lvl[1] > lt) || (str == 1 && lvl[0] > lvl[2])) pos = 1;
      else if ((str == 1 && lvl[2] > lvl[0]) || (str == 2 && lvl[1] > rt)) pos = 2;
      else if (str == 2 && lvl[1] <= rt && raw[2] > reg_rawlow) pos = 3;
      else pos = prv;
      gap = pos > prv ? pos - prv : prv - pos;
      if (gap > 1) pos = prv;
      cur_pos = 2'(pos);
      if (pos == 0 || pos == 3) begin
         mag = reg_lost > 300 ? 300 : int'(reg_lost);
         dev = pos == 0 ? -mag : mag;
      end else if (lvl[2] >= lvl[0]) begin
         mag = (lvl[2] - lvl[0]) >> 8;
         dev = mag > 300 ? 300 : mag;
      end else begin
         mag = (lvl[0] - lvl[2]) >> 8;
         dev = -(mag > 300 ? 300 : mag);
      end
      prev_center = 17'(lvl[1]);
      dv = dev[9:0];
      pending.push_back({7'd0, lvl[4][16:0], lvl[3][16:0], lvl[2][16:0], lvl[1][16:0],
                         lvl[0][16:0], dv, pos[1:0]});
   endfunction

   function void check_result(bit [103:0] got);
      bit [103:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $realtime, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (want[1:0] !== got[1:0]) begin
         $display("%0t: position exp %0d got %0d", $realtime, want[1:0], got[1:0]);
         errors++;
      end
      if (want[11:2] !== got[11:2]) begin
         $display("%0t: deviation exp %0d got %0d", $realtime,
                  $signed(want[11:2]), $signed(got[11:2]));
         errors++;
      end
      for (int i = 0; i < 5; i++)
         if (want[12+17*i +: 17] !== got[12+17*i +: 17]) begin
            $display("%0t: level %0d exp %0d got %0d", $realtime, i,
                     want[12+17*i +: 17], got[12+17*i +: 17]);
            errors++;
         end
   endfunction
endclass

module inductor_line_position_estimator_top_tb;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic         csr_wen = 0;
   logic [2:0]   csr_index = '0;
   logic [11:0]  csr_wdata = '0;
   estimate_board board = new();
   int           burst_left = 0;
   int           stall_mode = 0;

   inductor_line_position_estimator_top dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // receiver: stall pattern changes phase now and then
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 9) == 0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic write_csr(bit [2:0] idx, bit [11:0] val);
      @(posedge clock);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= val;
      board.write_reg(idx, val);
      @(posedge clock);
      csr_wen <= 0;
   endtask

   // drop valid, then wait until every item has come back
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // send one frame, with gaps between bursts; valid stays up inside a burst
   task automatic send_frame(bit [59:0] data, bit idle);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 300)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= {4'b0, data};
      req_tuser <= idle;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_frame(data, idle);
   endtask

   function automatic bit [59:0] pack5(int a, int b, int c, int d, int e);
      return {e[11:0], d[11:0], c[11:0], b[11:0], a[11:0]};
   endfunction

   task automatic random_frames(int n);
      int kind, base, s;
      for (int k = 0; k < n; k++) begin
         kind = $urandom_range(0, 9);
         s = $urandom_range(0, 12);
         base = $urandom_range(0, 700);
         if (kind < 2)       // calibration-like low, equal frame
            send_frame(pack5(base, base + $urandom_range(0, s), base + $urandom_range(0, s),
                             base + $urandom_range(0, s), base + $urandom_range(0, s)),
                       $urandom_range(0, 1));
         else if (kind < 4)  // full-range noise
            send_frame(60'({$urandom(), $urandom()}), $urandom_range(0, 1));
         else                // line under one side or center
            send_frame(pack5($urandom_range(0, 2400), $urandom_range(0, 2400),
                             $urandom_range(0, 2400), $urandom_range(0, 2400),
                             $urandom_range(0, 2400)), $urandom_range(0, 1));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed corners
      send_frame(pack5(0, 0, 0, 0, 0), 1);
      send_frame(pack5(4095, 4095, 4095, 4095, 4095), 1);
      send_frame(pack5(47, 47, 47, 47, 47), 0);
      send_frame(pack5(100, 102, 101, 100, 300), 0);
      send_frame(pack5(1500, 100, 100, 100, 100), 1);
      send_frame(pack5(1500, 100, 100, 100, 100), 0);
      send_frame(pack5(100, 1500, 100, 100, 100), 0);
      send_frame(pack5(100, 100, 1500, 100, 100), 0);
      send_frame(pack5(700, 100, 2000, 100, 100), 0);
      send_frame(pack5(100, 100, 3000, 100, 100), 0);
      send_frame(pack5(3000, 100, 100, 100, 100), 0);
      send_frame(pack5(60, 60, 60, 60, 60), 0);
      send_frame(pack5(4095, 0, 4095, 0, 4095), 1);
      drain();
      // extremes of the registers, with an unused index too
      write_csr(ilpe_pkg::REG_EQUAL_SPREAD, 0);
      write_csr(ilpe_pkg::REG_LOST_DEV, 12'h1FF);
      write_csr(ilpe_pkg::REG_RAW_LOW, 12'hFFF);
      write_csr(ilpe_pkg::REG_LEFT_TRANSIT, 255);
      write_csr(ilpe_pkg::REG_RIGHT_TRANSIT, 255);
      write_csr(ilpe_pkg::REG_MAX_CENTER, 255);
      write_csr(ilpe_pkg::REG_WEAK_SIGNAL, 255);
      write_csr(3'd7, 12'hFFF);
      send_frame(pack5(200, 200, 200, 200, 200), 1);
      send_frame(pack5(3000, 100, 100, 100, 100), 0);
      send_frame(pack5(100, 100, 3000, 100, 100), 0);
      random_frames(400);
      drain();
      write_csr(ilpe_pkg::REG_EQUAL_SPREAD, 255);
      write_csr(ilpe_pkg::REG_LOST_DEV, 0);
      write_csr(ilpe_pkg::REG_RAW_LOW, 0);
      write_csr(ilpe_pkg::REG_LEFT_TRANSIT, 0);
      write_csr(ilpe_pkg::REG_RIGHT_TRANSIT, 0);
      write_csr(ilpe_pkg::REG_MAX_CENTER, 0);
      write_csr(ilpe_pkg::REG_WEAK_SIGNAL, 0);
      random_frames(400);
      drain();
      write_csr(ilpe_pkg::REG_EQUAL_SPREAD, 5);
      write_csr(ilpe_pkg::REG_LOST_DEV, 300);
      write_csr(ilpe_pkg::REG_RAW_LOW, 500);
      write_csr(ilpe_pkg::REG_LEFT_TRANSIT, 30);
      write_csr(ilpe_pkg::REG_RIGHT_TRANSIT, 30);
      write_csr(ilpe_pkg::REG_MAX_CENTER, 90);
      write_csr(ilpe_pkg::REG_WEAK_SIGNAL, 5);
      random_frames(400);
      drain();
      write_csr(ilpe_pkg::REG_EQUAL_SPREAD, 1);
      write_csr(ilpe_pkg::REG_LOST_DEV, $urandom_range(0, 511));
      write_csr(ilpe_pkg::REG_RAW_LOW, $urandom_range(0, 4095));
      write_csr(ilpe_pkg::REG_LEFT_TRANSIT, $urandom_range(0, 255));
      write_csr(ilpe_pkg::REG_RIGHT_TRANSIT, $urandom_range(0, 255));
      write_csr(ilpe_pkg::REG_MAX_CENTER, $urandom_range(0, 255));
      write_csr(ilpe_pkg::REG_WEAK_SIGNAL, $urandom_range(0, 60));
      random_frames(300);
      drain();
      if (board.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // run limit
   initial begin
      #8000000;
      $display("simulation failed");
      $finish;
   end
endmodule
